>>> hdl/clpc_pkg.sv
// clpc_pkg: shared types and constants of the c lexical paren checker
// byte class codes, lexer states, status codes and the token passed
// from the front classifier through the queue to the back lexer
`timescale 1ns / 1ps

package clpc_pkg;

  localparam int DEPTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;

  typedef enum logic [3:0] {
    CLS_OTHER     = 4'd0,
    CLS_DQUOTE    = 4'd1,
    CLS_SQUOTE    = 4'd2,
    CLS_SLASH     = 4'd3,
    CLS_STAR      = 4'd4,
    CLS_LPAREN    = 4'd5,
    CLS_RPAREN    = 4'd6,
    CLS_NEWLINE   = 4'd7,
    CLS_BACKSLASH = 4'd8
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic        last;
  } token_t;

  typedef enum logic [7:0] {
    LX_TEXT   = 8'b0000_0001,
    LX_STRING = 8'b0000_0010,
    LX_BLOCK  = 8'b0000_0100,
    LX_LINE   = 8'b0000_1000,
    LX_SLASH  = 8'b0001_0000,
    LX_STAR   = 8'b0010_0000,
    LX_ESCAPE = 8'b0100_0000,
    LX_CHAR   = 8'b1000_0000
  } lex_state_t;

  localparam logic [2:0] ST_OK                = 3'd0;
  localparam logic [2:0] ST_UNFINISHED_STRING = 3'd1;
  localparam logic [2:0] ST_UNCLOSED_PAREN    = 3'd2;
  localparam logic [2:0] ST_UNMATCHED_PAREN   = 3'd3;
  localparam logic [2:0] ST_DEPTH_OVERFLOW    = 3'd4;

endpackage

>>> hdl/clpc_front.sv
// clpc_front: accepts source bytes and classifies them into tokens
// depends on clpc_pkg; output is a registered valid/ready stage
`timescale 1ns / 1ps

module clpc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      char_byte,
  input  logic            end_of_text,
  input  logic            in_valid,
  output logic            in_ready,
  output clpc_pkg::token_t tok,
  output logic            tok_valid,
  input  logic            tok_ready
);
  import clpc_pkg::*;

  char_class_t cls_next;

  always_comb begin
    case (char_byte)
      CH_DQUOTE:    cls_next = CLS_DQUOTE;
      CH_SQUOTE:    cls_next = CLS_SQUOTE;
      CH_SLASH:     cls_next = CLS_SLASH;
      CH_STAR:      cls_next = CLS_STAR;
      CH_LPAREN:    cls_next = CLS_LPAREN;
      CH_RPAREN:    cls_next = CLS_RPAREN;
      CH_NEWLINE:   cls_next = CLS_NEWLINE;
      CH_BACKSLASH: cls_next = CLS_BACKSLASH;
      default:      cls_next = CLS_OTHER;
    endcase
  end

  assign in_ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= in_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok.cls  <= cls_next;
      tok.last <= end_of_text;
    end
  end

endmodule

>>> hdl/clpc_queue.sv
// clpc_queue: short token queue between front and back
// depends on clpc_pkg for the token type and queue depth
`timescale 1ns / 1ps

module clpc_queue (
  input  logic             clk,
  input  logic             rst,
  input  clpc_pkg::token_t wr_tok,
  input  logic             wr_valid,
  output logic             wr_ready,
  output clpc_pkg::token_t rd_tok,
  output logic             rd_valid,
  input  logic             rd_ready
);
  import clpc_pkg::*;

  localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  token_t               slots [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CntBits-1:0]   count;
  logic                 push;
  logic                 pop;

  assign wr_ready = (count != CntBits'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_tok   = slots[rd_ptr];

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    if (p == PtrBits'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

endmodule

>>> hdl/clpc_back.sv
// clpc_back: lexer state machine, paren counter and status register
// depends on clpc_pkg; consumes tokens from clpc_queue
`timescale 1ns / 1ps

module clpc_back #(
  parameter int DEPTH_BITS = clpc_pkg::DEPTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  clpc_pkg::token_t tok,
  input  logic             tok_valid,
  output logic             tok_ready,
  output logic [2:0]       check_status,
  output logic             out_valid,
  input  logic             out_ready
);
  import clpc_pkg::*;

  lex_state_t            lex_state;
  lex_state_t            lex_state_next;
  logic [DEPTH_BITS-1:0] paren_depth;
  logic [DEPTH_BITS-1:0] paren_depth_next;
  logic [2:0]            latched_error;
  logic [2:0]            latched_error_next;
  logic [2:0]            status_now;
  logic                  take;

  // only a last token needs the output register free
  assign tok_ready = !tok.last || !out_valid || out_ready;
  assign take      = tok_valid && tok_ready;

  always_comb begin
    lex_state_next     = lex_state;
    paren_depth_next   = paren_depth;
    latched_error_next = latched_error;
    if (latched_error == ST_OK) begin
      case (lex_state)
        LX_TEXT, LX_SLASH: begin
          if (lex_state == LX_SLASH && tok.cls == CLS_STAR) begin
            lex_state_next = LX_BLOCK;
          end else if (lex_state == LX_SLASH && tok.cls == CLS_SLASH) begin
            lex_state_next = LX_LINE;
          end else begin
            // plain text handling, also for the byte after a lone slash
            case (tok.cls)
              CLS_DQUOTE: lex_state_next = LX_STRING;
              CLS_SQUOTE: lex_state_next = LX_CHAR;
              CLS_SLASH:  lex_state_next = LX_SLASH;
              CLS_LPAREN: begin
                lex_state_next = LX_TEXT;
                if (&paren_depth) begin
                  latched_error_next = ST_DEPTH_OVERFLOW;
                end else begin
                  paren_depth_next = paren_depth + 1'b1;
                end
              end
              CLS_RPAREN: begin
                lex_state_next = LX_TEXT;
                if (paren_depth == '0) begin
                  latched_error_next = ST_UNMATCHED_PAREN;
                end else begin
                  paren_depth_next = paren_depth - 1'b1;
                end
              end
              default: lex_state_next = LX_TEXT;
            endcase
          end
        end
        LX_CHAR: begin
          if (tok.cls == CLS_SQUOTE) lex_state_next = LX_TEXT;
        end
        LX_LINE: begin
          if (tok.cls == CLS_NEWLINE) lex_state_next = LX_TEXT;
        end
        LX_BLOCK: begin
          if (tok.cls == CLS_STAR) lex_state_next = LX_STAR;
        end
        LX_STAR: begin
          if (tok.cls == CLS_SLASH) begin
            lex_state_next = LX_TEXT;
          end else if (tok.cls != CLS_STAR) begin
            lex_state_next = LX_BLOCK;
          end
        end
        LX_STRING: begin
          if (tok.cls == CLS_DQUOTE) begin
            lex_state_next = LX_TEXT;
          end else if (tok.cls == CLS_NEWLINE) begin
            latched_error_next = ST_UNFINISHED_STRING;
          end else if (tok.cls == CLS_BACKSLASH) begin
            lex_state_next = LX_ESCAPE;
          end
        end
        LX_ESCAPE: begin
          if (tok.cls == CLS_NEWLINE) begin
            latched_error_next = ST_UNFINISHED_STRING;
          end else begin
            lex_state_next = LX_STRING;
          end
        end
        default: lex_state_next = LX_TEXT;
      endcase
    end
  end

  always_comb begin
    if (latched_error_next != ST_OK) begin
      status_now = latched_error_next;
    end else if (paren_depth_next != '0) begin
      status_now = ST_UNCLOSED_PAREN;
    end else begin
      status_now = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state     <= LX_TEXT;
      paren_depth   <= '0;
      latched_error <= ST_OK;
      out_valid     <= 1'b0;
    end else begin
      if (take && tok.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (tok.last) begin
          lex_state     <= LX_TEXT;
          paren_depth   <= '0;
          latched_error <= ST_OK;
        end else begin
          lex_state     <= lex_state_next;
          paren_depth   <= paren_depth_next;
          latched_error <= latched_error_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok.last) begin
      check_status <= status_now;
    end
  end

endmodule

>>> hdl/c_lexical_paren_checker.sv
// c_lexical_paren_checker: top level of the comment and string aware
// paren checker; instantiates clpc_front, clpc_queue and clpc_back
//
// usage:
//   input channel: char_byte and end_of_text with in_valid / in_ready.
//     one byte of c source per transaction; end_of_text marks the last
//     byte of a stream.
//   output channel: check_status with out_valid / out_ready. exactly one
//     transaction per stream, carrying ok, unfinished string, unclosed
//     paren, unmatched paren or depth overflow.
//   throughput: one byte per cycle unless a last byte waits on a status
//     not yet taken; each byte updates back lexer state, depth and latched error.
//   path: a last byte passes the front classify register, the queue and
//     the back status register before out_valid rises.
//   stall: while a status waits in the output register, bytes that are
//     not last keep flowing; a new last byte waits in the queue until the
//     status is taken, and the queue then backs up into in_ready.
//   reset: rst synchronous, active high; lexer returns to plain text,
//     depth and error clear, the queue empties. each stream end also
//     returns the lexer to that state for the next stream.
//   DEPTH_BITS sets the paren counter width; an open paren at all ones flags depth overflow.
`timescale 1ns / 1ps

module c_lexical_paren_checker #(
  parameter int DEPTH_BITS = clpc_pkg::DEPTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_byte,
  input  logic       end_of_text,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [2:0] check_status,
  output logic       out_valid,
  input  logic       out_ready
);
  import clpc_pkg::*;

  // classified token from the front register
  token_t f_tok;
  logic   f_valid;
  logic   f_ready;

  // token at the head of the queue
  token_t q_tok;
  logic   q_valid;
  logic   q_ready;

  // front: byte classification into a token register
  clpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_byte   (char_byte),
    .end_of_text (end_of_text),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tok         (f_tok),
    .tok_valid   (f_valid),
    .tok_ready   (f_ready)
  );

  // queue decouples the front from a back stalled on the status output
  clpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_tok   (f_tok),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_tok   (q_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // back: lexer, paren depth and status output register
  clpc_back #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tok          (q_tok),
    .tok_valid    (q_valid),
    .tok_ready    (q_ready),
    .check_status (check_status),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule
